[hw/rtl/bds_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_pkg
// Shared types, constants and helpers of the power-of-two box downscaler.
// ----------------------------------------------------------------------------
package bds_pkg;

  // Default build limits
  localparam int BDS_MAX_WIDTH = 4096;
  localparam int BDS_MAX_POWER = 4;

  // Fixed field widths
  localparam int PIX_W        = 8;
  localparam int WIDTH_REG_W  = 13;
  localparam int HEIGHT_REG_W = 13;
  localparam int POWER_REG_W  = 3;
  localparam int HEIGHT_MAX   = 4096;
  localparam int ROW_W        = 12;

  // Block-result queue between front and back
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // Configuration port
  localparam int CFG_ADDR_W = 4;
  localparam int CFG_DATA_W = 32;
  localparam int REG_IDX_W  = 2;

  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_SCALE_POWER  = 2'd2;

  localparam logic [WIDTH_REG_W-1:0]  RST_IMAGE_WIDTH  = 13'd640;
  localparam logic [HEIGHT_REG_W-1:0] RST_IMAGE_HEIGHT = 13'd480;
  localparam logic [POWER_REG_W-1:0]  RST_SCALE_POWER  = 3'd3;

  typedef struct packed {
    logic [WIDTH_REG_W-1:0]  image_width;
    logic [HEIGHT_REG_W-1:0] image_height;
    logic [POWER_REG_W-1:0]  scale_power;
  } cfg_t;

  // Flags that travel with each block sum through the queue
  typedef struct packed {
    logic frame_end;
    logic full;
  } job_flags_t;

  typedef struct packed {
    logic [Q_CNT_W-1:0] count;
    logic               empty;
  } q_status_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIVIDE,
    BK_DONE
  } back_state_t;

  // Block sum width: 2^(2p) pixels of 8 bits
  function automatic int sum_width(input int max_power);
    return PIX_W + 2 * max_power;
  endfunction

  // Pixel count width: up to 2^p by 2^p
  function automatic int cnt_width(input int max_power);
    return 2 * max_power + 2;
  endfunction

  function automatic int job_width(input int max_power);
    return 3 * sum_width(max_power) + cnt_width(max_power) + $bits(job_flags_t);
  endfunction

  // Limit the scale register to the build maximum
  function automatic logic [POWER_REG_W-1:0] clamp_power(
    input logic [POWER_REG_W-1:0] power,
    input int                     max_power
  );
    logic [POWER_REG_W-1:0] lim;
    lim = POWER_REG_W'(max_power);
    return (power > lim) ? lim : power;
  endfunction

endpackage

[hw/rtl/bds_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_front
// Accepts pixels, tracks raster position, accumulates block sums in the
// line store and pushes each finished block sum with its pixel count.
// ----------------------------------------------------------------------------
module bds_front #(
  parameter int  MAX_WIDTH = 4096,
  parameter int  MAX_POWER = 4,
  localparam int JOB_W     = bds_pkg::job_width(MAX_POWER)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  bds_pkg::cfg_t            cfg,
  input  logic                     cfg_clear,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [bds_pkg::PIX_W-1:0] in_luma,
  input  logic [bds_pkg::PIX_W-1:0] in_chroma_blue,
  input  logic [bds_pkg::PIX_W-1:0] in_chroma_red,
  input  bds_pkg::q_status_t       q_status,
  output logic                     push,
  output logic [JOB_W-1:0]         job
);
  import bds_pkg::*;

  localparam int COL_W  = $clog2(MAX_WIDTH);
  localparam int WID_W  = $clog2(MAX_WIDTH) + 1;
  localparam int PW0    = (WID_W > WIDTH_REG_W + 1) ? WID_W : WIDTH_REG_W + 1;
  localparam int PW     = (PW0 > MAX_POWER + 2) ? PW0 : MAX_POWER + 2;
  localparam int SUM_W  = sum_width(MAX_POWER);
  localparam int CNT_W  = cnt_width(MAX_POWER);
  localparam int SIDE_W = MAX_POWER + 1;

  // Position of the next pixel
  logic [COL_W-1:0] col, col_next;
  logic [ROW_W-1:0] row, row_next;

  logic [POWER_REG_W-1:0] k;
  logic [PW-1:0]          w, h, x, y, side, mask, xm, ym, rx, ry;
  logic                   x_end, y_end, first, last_x, last_y, full, accept;
  logic [SIDE_W-1:0]      cw, ch;
  logic [CNT_W-1:0]       cnt;
  logic [COL_W-1:0]       bi;
  logic [Q_CNT_W:0]       pending;

  // Accumulate stage
  logic                 b_valid;
  logic [COL_W-1:0]     b_addr;
  logic                 b_first;
  logic                 b_last;
  logic [PIX_W-1:0]     b_pix [3];
  logic [CNT_W-1:0]     b_cnt;
  job_flags_t           b_flags;
  logic [3*SUM_W-1:0]   b_base, b_sum;

  // Line store and last-write bypass
  logic [3*SUM_W-1:0]   line_mem [MAX_WIDTH];
  logic [3*SUM_W-1:0]   rd_data;
  logic                 wr_valid;
  logic [COL_W-1:0]     wr_addr;
  logic [3*SUM_W-1:0]   wr_data;

  // Clamp configuration and classify the current position
  always_comb begin
    k = clamp_power(cfg.scale_power, MAX_POWER);
    if (cfg.image_width == '0) begin
      w = PW'(1);
    end else if (PW'(cfg.image_width) > PW'(MAX_WIDTH)) begin
      w = PW'(MAX_WIDTH);
    end else begin
      w = PW'(cfg.image_width);
    end
    if (cfg.image_height == '0) begin
      h = PW'(1);
    end else if (PW'(cfg.image_height) > PW'(HEIGHT_MAX)) begin
      h = PW'(HEIGHT_MAX);
    end else begin
      h = PW'(cfg.image_height);
    end
    x      = PW'(col);
    y      = PW'(row);
    side   = PW'(1) << k;
    mask   = side - PW'(1);
    xm     = x & mask;
    ym     = y & mask;
    x_end  = (x + PW'(1)) == w;
    y_end  = (y + PW'(1)) == h;
    first  = (xm == '0) && (ym == '0);
    last_x = (xm == mask) || x_end;
    last_y = (ym == mask) || y_end;
    // Pixels present in this block, edge blocks included
    rx     = w - (x & ~mask);
    ry     = h - (y & ~mask);
    cw     = (rx < side) ? SIDE_W'(rx) : SIDE_W'(side);
    ch     = (ry < side) ? SIDE_W'(ry) : SIDE_W'(side);
    cnt    = CNT_W'(cw) * CNT_W'(ch);
    full   = (cw == SIDE_W'(side)) && (ch == SIDE_W'(side));
    bi     = col >> k;
  end

  // Hold input while the queue could overflow
  always_comb begin
    pending  = {1'b0, q_status.count} + {{Q_CNT_W{1'b0}}, b_valid & b_last};
    in_stall = pending >= (Q_CNT_W + 1)'(Q_DEPTH);
    accept   = in_valid & ~in_stall;
  end

  // Advance raster position
  always_comb begin
    if (x_end) begin
      col_next = '0;
      row_next = y_end ? '0 : row + ROW_W'(1);
    end else begin
      col_next = col + COL_W'(1);
      row_next = row;
    end
  end

  always_ff @(posedge clk) begin
    if (rst || cfg_clear) begin
      col <= '0;
      row <= '0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
    end
  end

  // Load the accumulate stage
  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else begin
      b_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_addr            <= bi;
      b_first           <= first;
      b_last            <= last_x && last_y;
      b_pix[0]          <= in_luma;
      b_pix[1]          <= in_chroma_blue;
      b_pix[2]          <= in_chroma_red;
      b_cnt             <= cnt;
      b_flags.full      <= full;
      b_flags.frame_end <= x_end && y_end;
    end
  end

  // Read on accept, write back from the accumulate stage
  always_ff @(posedge clk) begin
    if (accept) begin
      rd_data <= line_mem[bi];
    end
    if (b_valid) begin
      line_mem[b_addr] <= b_sum;
    end
  end

  // Remember the last write to cover a read of the same entry
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_valid <= 1'b0;
    end else if (b_valid) begin
      wr_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (b_valid) begin
      wr_addr <= b_addr;
      wr_data <= b_sum;
    end
  end

  // Restart the sum on the first pixel of a block, else add to it
  always_comb begin
    if (b_first) begin
      b_base = '0;
    end else if (wr_valid && (wr_addr == b_addr)) begin
      b_base = wr_data;
    end else begin
      b_base = rd_data;
    end
    for (int c = 0; c < 3; c++) begin
      b_sum[c*SUM_W +: SUM_W] = b_base[c*SUM_W +: SUM_W] + SUM_W'(b_pix[c]);
    end
  end

  // Push the finished block
  assign push = b_valid & b_last;
  assign job  = {b_flags, b_cnt, b_sum};

endmodule

[hw/rtl/bds_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_queue
// Short first-in first-out queue of finished block sums.
// ----------------------------------------------------------------------------
module bds_queue #(
  parameter int DATA_W = 1
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  logic [DATA_W-1:0]  din,
  input  logic               pop,
  output logic [DATA_W-1:0]  dout,
  output bds_pkg::q_status_t status
);
  import bds_pkg::*;

  logic [DATA_W-1:0]  slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr, rd_ptr;
  logic [Q_CNT_W-1:0] count;

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + Q_PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + Q_PTR_W'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + Q_CNT_W'(1);
        2'b01:   count <= count - Q_CNT_W'(1);
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= din;
    end
  end

  assign dout         = slots[rd_ptr];
  assign status.count = count;
  assign status.empty = (count == '0);

endmodule

[hw/rtl/bds_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bds_back
// Turns block sums into averages: a shift for whole blocks, an iterative
// divider for blocks cut off at the image edge, then the output register.
// ----------------------------------------------------------------------------
module bds_back #(
  parameter int  MAX_POWER = 4,
  localparam int JOB_W     = bds_pkg::job_width(MAX_POWER)
) (
  input  logic                      clk,
  input  logic                      rst,
  input  bds_pkg::cfg_t             cfg,
  input  bds_pkg::q_status_t        q_status,
  input  logic [JOB_W-1:0]          job,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic [bds_pkg::PIX_W-1:0] out_luma,
  output logic [bds_pkg::PIX_W-1:0] out_chroma_blue,
  output logic [bds_pkg::PIX_W-1:0] out_chroma_red,
  output logic                      frame_end
);
  import bds_pkg::*;

  localparam int SUM_W  = sum_width(MAX_POWER);
  localparam int CNT_W  = cnt_width(MAX_POWER);
  localparam int DEN_W  = CNT_W + PIX_W - 1;
  localparam int STEP_W = $clog2(PIX_W);
  localparam int FLG_W  = $bits(job_flags_t);

  back_state_t state, state_next;

  logic [SUM_W-1:0]       job_sum [3];
  logic [CNT_W-1:0]       job_cnt;
  job_flags_t             job_flags;
  logic [POWER_REG_W-1:0] k;
  logic                   out_free, load_fast, load_div, load_slow;

  // Divider registers
  logic [DEN_W-1:0]  rem [3];
  logic [PIX_W-1:0]  quo [3];
  logic [DEN_W-1:0]  den;
  logic [STEP_W-1:0] step;
  logic              div_fend;

  // Unpack the head of the queue
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      job_sum[c] = job[c*SUM_W +: SUM_W];
    end
    job_cnt   = job[3*SUM_W +: CNT_W];
    job_flags = job_flags_t'(job[JOB_W-1 -: FLG_W]);
    k         = clamp_power(cfg.scale_power, MAX_POWER);
    out_free  = !out_valid || !out_stall;
  end

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty && !job_flags.full) begin
          state_next = BK_DIVIDE;
        end
      end
      BK_DIVIDE: begin
        if (step == STEP_W'(PIX_W - 1)) begin
          state_next = BK_DONE;
        end
      end
      BK_DONE: begin
        if (out_free) begin
          state_next = BK_IDLE;
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    pop       = 1'b0;
    load_fast = 1'b0;
    load_div  = 1'b0;
    load_slow = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!q_status.empty) begin
          if (job_flags.full) begin
            pop       = out_free;
            load_fast = out_free;
          end else begin
            pop      = 1'b1;
            load_div = 1'b1;
          end
        end
      end
      BK_DIVIDE: begin
        load_slow = 1'b0;
      end
      BK_DONE: begin
        load_slow = out_free;
      end
      default: begin
        pop = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= BK_IDLE;
      step  <= '0;
    end else begin
      state <= state_next;
      if (load_div) begin
        step <= '0;
      end else if (state == BK_DIVIDE) begin
        step <= step + STEP_W'(1);
      end
    end
  end

  // Restoring division, one quotient bit per cycle on all three channels
  always_ff @(posedge clk) begin
    if (load_div) begin
      for (int c = 0; c < 3; c++) begin
        rem[c] <= DEN_W'(job_sum[c]);
        quo[c] <= '0;
      end
      den      <= DEN_W'(job_cnt) << (PIX_W - 1);
      div_fend <= job_flags.frame_end;
    end else if (state == BK_DIVIDE) begin
      for (int c = 0; c < 3; c++) begin
        if (rem[c] >= den) begin
          rem[c] <= rem[c] - den;
          quo[c] <= {quo[c][PIX_W-2:0], 1'b1};
        end else begin
          quo[c] <= {quo[c][PIX_W-2:0], 1'b0};
        end
      end
      den <= den >> 1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_fast || load_slow) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_fast) begin
      out_luma        <= PIX_W'(job_sum[0] >> {k, 1'b0});
      out_chroma_blue <= PIX_W'(job_sum[1] >> {k, 1'b0});
      out_chroma_red  <= PIX_W'(job_sum[2] >> {k, 1'b0});
      frame_end       <= job_flags.frame_end;
    end else if (load_slow) begin
      out_luma        <= quo[0];
      out_chroma_blue <= quo[1];
      out_chroma_red  <= quo[2];
      frame_end       <= div_fend;
    end
  end

endmodule

[hw/rtl/box_downscale_pow2_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_downscale_pow2_top
// Power-of-two box-filter downscaler for a raster YCbCr pixel stream.
//
//   port group  direction  handshake            word
//   in_*        input      in_valid / in_stall  one input pixel (Y, Cb, Cr)
//   out_*       output     out_valid/out_stall  one block average + frame_end
//   p*          config     APB write/read       image_width/height, scale_power
//
// The front takes one pixel per cycle while in_stall is low; the line store
// read-modify-write is pipelined with a bypass of the last write. A whole
// block is shifted from the queue head into the output register; a block
// cut off at the image edge goes through the 8-step divider. Reset clears
// positions and control only; the line store needs no clearing pass. A
// stalled output fills the 4-entry queue, after which in_stall rises.
// ----------------------------------------------------------------------------
module box_downscale_pow2_top #(
  parameter int MAX_WIDTH = bds_pkg::BDS_MAX_WIDTH,
  parameter int MAX_POWER = bds_pkg::BDS_MAX_POWER
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [bds_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [bds_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [bds_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [bds_pkg::PIX_W-1:0]      in_luma,
  input  logic [bds_pkg::PIX_W-1:0]      in_chroma_blue,
  input  logic [bds_pkg::PIX_W-1:0]      in_chroma_red,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [bds_pkg::PIX_W-1:0]      out_luma,
  output logic [bds_pkg::PIX_W-1:0]      out_chroma_blue,
  output logic [bds_pkg::PIX_W-1:0]      out_chroma_red,
  output logic                           frame_end
);
  import bds_pkg::*;

  localparam int JOB_W = job_width(MAX_POWER);

  cfg_t                 cfg;
  logic                 cfg_wr, cfg_clear;
  logic [REG_IDX_W-1:0] reg_idx;
  logic                 push, pop;
  logic [JOB_W-1:0]     job_in, job_out;
  q_status_t            q_status;

  // Decode the register word
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_W-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_clear = 1'b0;
    unique case (reg_idx) inside
      REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT, REG_SCALE_POWER: cfg_clear = cfg_wr;
      default: cfg_clear = 1'b0;
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.image_width  <= RST_IMAGE_WIDTH;
      cfg.image_height <= RST_IMAGE_HEIGHT;
      cfg.scale_power  <= RST_SCALE_POWER;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_IMAGE_WIDTH:  cfg.image_width  <= pwdata[WIDTH_REG_W-1:0];
        REG_IMAGE_HEIGHT: cfg.image_height <= pwdata[HEIGHT_REG_W-1:0];
        REG_SCALE_POWER:  cfg.scale_power  <= pwdata[POWER_REG_W-1:0];
        default:          cfg              <= cfg;
      endcase
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      REG_IMAGE_WIDTH:  prdata = CFG_DATA_W'(cfg.image_width);
      REG_IMAGE_HEIGHT: prdata = CFG_DATA_W'(cfg.image_height);
      REG_SCALE_POWER:  prdata = CFG_DATA_W'(cfg.scale_power);
      default:          prdata = '0;
    endcase
  end

  bds_front #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_POWER (MAX_POWER)
  ) u_front (
    .clk            (clk),
    .rst            (rst),
    .cfg            (cfg),
    .cfg_clear      (cfg_clear),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_luma        (in_luma),
    .in_chroma_blue (in_chroma_blue),
    .in_chroma_red  (in_chroma_red),
    .q_status       (q_status),
    .push           (push),
    .job            (job_in)
  );

  bds_queue #(
    .DATA_W (JOB_W)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .din    (job_in),
    .pop    (pop),
    .dout   (job_out),
    .status (q_status)
  );

  bds_back #(
    .MAX_POWER (MAX_POWER)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .cfg             (cfg),
    .q_status        (q_status),
    .job             (job_out),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_luma        (out_luma),
    .out_chroma_blue (out_chroma_blue),
    .out_chroma_red  (out_chroma_red),
    .frame_end       (frame_end)
  );

endmodule
